// ----- sv/icon_slot_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// Icon slot allocator assertion macros
// Shared concurrent-assertion shorthands for the icon slot allocator.
// ----------------------------------------------------------------------------
`ifndef ICON_SLOT_ALLOCATOR_DEFINES_SVH
`define ICON_SLOT_ALLOCATOR_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define ISA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("icon slot allocator: same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define ISA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("icon slot allocator: next-cycle check failed");

`endif

// ----- sv/isa_pkg.sv -----
// ----------------------------------------------------------------------------
// Icon slot allocator package
// Shared widths, operation codes, control structs and the tile arithmetic.
// ----------------------------------------------------------------------------
package isa_pkg;

   localparam int ICON_COUNT_DEF = 768;
   localparam int SLOT_COUNT_DEF = 32;

   localparam int OP_W       = 2;
   localparam int ICON_W     = 11;   // signed icon id
   localparam int ICON_NUM_W = 10;   // magnitude bits of a non-negative id
   localparam int PAL_W      = 16;
   localparam int TILE_W     = 16;
   localparam int SLOT_NUM_W = 6;    // slot + 1, zero meaning no slot
   localparam int REQ_DATA_W = 32;   // icon_id, pal_base, zero fill
   localparam int RSP_DATA_W = 16;   // first_tile
   localparam int RSP_USER_W = 3;    // blank, newly_loaded, full_res

   localparam logic [TILE_W-1:0] TILE_TOP = 16'h0300;

   typedef enum logic [OP_W-1:0] {
      OP_DRAW      = 2'd0,
      OP_CLEAR     = 2'd1,
      OP_RESET_ALL = 2'd2
   } op_type;

   typedef struct packed {
      logic alloc;
      logic release_slot;
      logic clear_all;
   } pool_cmd_type;

   typedef struct packed {
      logic                  hit;
      logic                  found;
      logic [SLOT_NUM_W-1:0] free_num;   // lowest free slot + 1
   } pool_stat_type;

   // First tile of a slot: top minus four tiles per slot, plus the palette bits.
   function automatic logic [TILE_W-1:0] tile_word(input logic [SLOT_NUM_W-1:0] num,
                                                   input logic [PAL_W-1:0]      pal);
      logic [TILE_W-1:0] offs;
      offs = TILE_W'({num, 2'b00});
      return TILE_TOP - offs + pal;
   endfunction

endpackage

// ----- sv/isa_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module isa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/isa_slot_pool.sv -----
// ----------------------------------------------------------------------------
// Icon slot pool
// Owner records per slot, ownership check and lowest-free-slot search.
// ----------------------------------------------------------------------------
module isa_slot_pool #(
   parameter int SLOT_COUNT = 32
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic [isa_pkg::SLOT_NUM_W-1:0]             held_num,
   input  logic [isa_pkg::ICON_NUM_W-1:0]             icon_num,
   input  isa_pkg::pool_cmd_type                      cmd,
   output isa_pkg::pool_stat_type                     stat
);

   import isa_pkg::*;

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   logic [SLOT_COUNT-1:0] owner_vld_ff;
   logic [SLOT_COUNT-1:0] owner_vld_in;
   logic [ICON_NUM_W-1:0] owner_id_ff [SLOT_COUNT];
   logic                  in_pool;
   logic [SLOT_W-1:0]     held_idx;
   logic [SLOT_W-1:0]     free_idx;
   logic                  found;
   logic                  hit;
   logic [SLOT_NUM_W-1:0] free_num;

   // A stored slot number counts only while the slot still names this icon.
   always_comb begin
      in_pool  = (held_num != '0) && (32'(held_num) <= 32'(SLOT_COUNT));
      held_idx = SLOT_W'(held_num - SLOT_NUM_W'(1));
      hit      = 1'b0;
      if (in_pool) begin
         hit = owner_vld_ff[held_idx] && (owner_id_ff[held_idx] == icon_num);
      end
   end

   // Lowest free slot wins.
   always_comb begin
      found    = 1'b0;
      free_idx = '0;
      for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
         if (!owner_vld_ff[s]) begin
            found    = 1'b1;
            free_idx = SLOT_W'(s);
         end
      end
      free_num = SLOT_NUM_W'(free_idx) + SLOT_NUM_W'(1);
   end

   assign stat = '{hit: hit, found: found, free_num: free_num};

   always_comb begin
      owner_vld_in = owner_vld_ff;
      if (cmd.clear_all) begin
         owner_vld_in = '0;
      end else if (cmd.alloc) begin
         owner_vld_in[free_idx] = 1'b1;
      end else if (cmd.release_slot && in_pool) begin
         owner_vld_in[held_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owner_vld_ff <= '0;
      end else begin
         owner_vld_ff <= owner_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         owner_id_ff[free_idx] <= icon_num;
      end
   end

endmodule

// ----- sv/icon_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// Icon slot allocator
// Maps icon ids onto a small pool of graphics slots and returns tile numbers.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Beat contents
//  --------+-----------+-----------------------------------------------------
//  req_    | in        | tuser: operation; tdata: icon_id, pal_base
//  rsp_    | out       | tdata: first_tile; tuser: blank, newly_loaded, full_res
//
//  One beat is taken every cycle while req_tready is high; rsp_tvalid rises
//  once the decide stage hands its beat on to the output register (icon table
//  read, then decide and write back).
//  After reset a clearing pass writes zero to every icon table entry, one
//  per cycle; req_tready stays low meanwhile.
//  A stalled rsp_ beat holds the pipeline; req_tready drops only during the
//  clearing pass or when the decide stage cannot hand its beat on.
//  The reset-all operation empties the slot owners, and stale icon table
//  entries are rejected by the ownership check.
//
module icon_slot_allocator #(
   parameter int ICON_COUNT = isa_pkg::ICON_COUNT_DEF,
   parameter int SLOT_COUNT = isa_pkg::SLOT_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [isa_pkg::REQ_DATA_W-1:0]  req_tdata,   // [10:0] icon_id, [26:11] pal_base
   input  logic [isa_pkg::OP_W-1:0]        req_tuser,   // [1:0] operation
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [isa_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [15:0] first_tile
   output logic [isa_pkg::RSP_USER_W-1:0]  rsp_tuser    // [0] blank, [1] newly_loaded,
                                                        // [2] full_res
);

   import isa_pkg::*;

`include "icon_slot_allocator_defines.svh"

   localparam int IDX_W = (ICON_COUNT > 1) ? $clog2(ICON_COUNT) : 1;

   typedef enum logic [1:0] {
      ST_SWEEP = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   // ---------------------------------------------------------------- control
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  sweep_addr_ff, sweep_addr_in;

   // ------------------------------------------------------- decide stage (s1)
   logic                 s1_vld_ff, s1_vld_in;
   op_type               s1_op_ff;
   logic [ICON_W-1:0]    s1_icon_ff;
   logic [PAL_W-1:0]     s1_pal_ff;
   logic                 byp_vld_ff, byp_vld_in;
   logic [SLOT_NUM_W-1:0] byp_num_ff;

   // ----------------------------------------------------------- output beat
   logic                 rsp_vld_ff, rsp_vld_in;
   logic [TILE_W-1:0]    rsp_tile_ff;
   logic [RSP_USER_W-1:0] rsp_flags_ff;

   logic                 req_fire;
   logic                 s1_adv;
   logic [IDX_W-1:0]     req_idx;
   logic [IDX_W-1:0]     s1_idx;
   logic [SLOT_NUM_W-1:0] ram_rd_num;
   logic [SLOT_NUM_W-1:0] held_num;

   logic                 s1_neg;
   logic                 s1_in_range;
   logic [TILE_W-1:0]    res_tile;
   logic                 res_blank;
   logic                 res_fresh;
   logic                 res_full;
   logic                 tbl_wr;
   logic [SLOT_NUM_W-1:0] tbl_wr_num;

   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic [SLOT_NUM_W-1:0] ram_wr_data;

   pool_cmd_type         pool_cmd;
   pool_stat_type        pool_stat;

   // --------------------------------------------------------------- handshake
   assign s1_adv     = s1_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = (state_ff == ST_RUN) && (!s1_vld_ff || s1_adv);
   assign req_fire   = req_tvalid && req_tready;

   assign req_idx = IDX_W'(req_tdata[ICON_NUM_W-1:0]);
   assign s1_idx  = IDX_W'(s1_icon_ff[ICON_NUM_W-1:0]);

   // ------------------------------------------------------------ clearing pass
   always_comb begin
      state_in      = state_ff;
      sweep_addr_in = sweep_addr_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            sweep_addr_in = sweep_addr_ff + IDX_W'(1);
            if (sweep_addr_ff == IDX_W'(ICON_COUNT - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            sweep_addr_in = '0;
         end
         default: begin
            state_in = ST_SWEEP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_addr_ff <= '0;
      end else begin
         state_ff      <= state_in;
         sweep_addr_ff <= sweep_addr_in;
      end
   end

   // -------------------------------------------------------------- icon table
   // Sweep writes win; otherwise the decide stage writes back as it hands on.
   always_comb begin
      if (state_ff == ST_SWEEP) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = sweep_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = s1_adv && tbl_wr;
         ram_wr_addr = s1_idx;
         ram_wr_data = tbl_wr_num;
      end
   end

   isa_ram #(
      .WIDTH (SLOT_NUM_W),
      .DEPTH (ICON_COUNT)
   ) u_icon_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_idx),
      .rd_data (ram_rd_num)
   );

   // Forward a write-back that lands on the entry being read in the same cycle.
   assign byp_vld_in = s1_adv && tbl_wr && (s1_idx == req_idx);
   assign held_num   = byp_vld_ff ? byp_num_ff : ram_rd_num;

   // -------------------------------------------------------------- slot pool
   isa_slot_pool #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_slot_pool (
      .clock    (clock),
      .reset    (reset),
      .held_num (held_num),
      .icon_num (s1_icon_ff[ICON_NUM_W-1:0]),
      .cmd      (pool_cmd),
      .stat     (pool_stat)
   );

   // ------------------------------------------------------------ decide logic
   assign s1_neg      = s1_icon_ff[ICON_W-1];
   assign s1_in_range = !s1_neg &&
                        (32'(s1_icon_ff[ICON_NUM_W-1:0]) < 32'(ICON_COUNT));

   always_comb begin
      res_tile     = '0;
      res_blank    = 1'b0;
      res_fresh    = 1'b0;
      res_full     = 1'b0;
      tbl_wr       = 1'b0;
      tbl_wr_num   = '0;
      pool_cmd     = '0;
      unique case (s1_op_ff)
         OP_DRAW: begin
            if (s1_neg) begin
               res_blank = 1'b1;
            end else if (!s1_in_range) begin
               res_full = 1'b1;
               res_tile = TILE_TOP + s1_pal_ff;
            end else if (pool_stat.hit) begin
               res_tile = tile_word(held_num, s1_pal_ff);
            end else if (pool_stat.found) begin
               // Miss: claim the lowest free slot and flag a graphics load.
               res_fresh      = 1'b1;
               res_tile       = tile_word(pool_stat.free_num, s1_pal_ff);
               tbl_wr         = 1'b1;
               tbl_wr_num     = pool_stat.free_num;
               pool_cmd.alloc = s1_adv;
            end else begin
               res_full = 1'b1;
               res_tile = TILE_TOP + s1_pal_ff;
            end
         end
         OP_CLEAR: begin
            // Drop the icon's slot only if it really holds one.
            if (s1_in_range && pool_stat.hit) begin
               tbl_wr                = 1'b1;
               tbl_wr_num            = '0;
               pool_cmd.release_slot = s1_adv;
            end
         end
         OP_RESET_ALL: begin
            pool_cmd.clear_all = s1_adv;
         end
         default: begin
            // Unused code: answer with an all-zero beat.
         end
      endcase
   end

   // ----------------------------------------------------------- pipeline regs
   assign s1_vld_in  = req_fire || (s1_vld_ff && !s1_adv);
   assign rsp_vld_in = s1_adv || (rsp_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         byp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (req_fire) begin
            byp_vld_ff <= byp_vld_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff   <= op_type'(req_tuser);
         s1_icon_ff <= req_tdata[ICON_W-1:0];
         s1_pal_ff  <= req_tdata[ICON_W +: PAL_W];
         byp_num_ff <= tbl_wr_num;
      end
      if (s1_adv) begin
         rsp_tile_ff  <= res_tile;
         rsp_flags_ff <= {res_full, res_fresh, res_blank};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_tile_ff;
   assign rsp_tuser  = rsp_flags_ff;

   // -------------------------------------------------------------- assertions
   `ISA_ASSERT_NOW(a_no_take_in_sweep, clock, reset, state_ff == ST_SWEEP, !req_tready)
   `ISA_ASSERT_NOW(a_alloc_needs_free, clock, reset, pool_cmd.alloc, pool_stat.found && !pool_stat.hit)
   `ISA_ASSERT_NOW(a_flags_exclusive, clock, reset, rsp_vld_ff, $countones(rsp_flags_ff) <= 1)
   `ISA_ASSERT_NOW(a_blank_zero_tile, clock, reset, rsp_vld_ff && rsp_flags_ff[0], rsp_tile_ff == '0)
   `ISA_ASSERT_NEXT(a_fresh_then_rsp, clock, reset, pool_cmd.alloc, rsp_vld_ff && rsp_flags_ff[1])

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Icon slot allocator testbench
// Streams draw, clear, reset-all and spare-code requests into the allocator. A
// local copy of the icon table and slot owners predicts every result beat, and
// each beat returned is checked field by field. Both sides idle at random, and
// the result side holds off once for a long stretch so the request side stalls.
// ----------------------------------------------------------------------------
module testbench;
   import isa_pkg::*;

   // Unused operation code: the block ignores it and answers all zeros.
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   localparam int SET_SIZE        = 40;      // icons in the working set, above the slot count
   localparam int FILL_DRAWS      = 34;      // enough distinct draws to exhaust the pool
   localparam int RANDOM_ITEMS    = 470;
   localparam int IDLE_PCT        = 30;
   localparam int QUIET_FROM      = 300;     // beats with no idling on either side
   localparam int QUIET_TO        = 400;
   localparam int HOLD_OFF_AT     = 200;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 16;
   localparam int CYCLE_LIMIT     = 100000;  // covers the clearing pass after reset

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ICON_W-1:0] icon;
      logic [PAL_W-1:0]  pal;
   } icon_request_type;

   typedef struct packed {
      logic [TILE_W-1:0] first_tile;
      logic              blank;
      logic              newly_loaded;
      logic              full_res;
   } tile_answer_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [10:0] icon_id, [26:11] pal_base
   logic [OP_W-1:0]       req_tuser  = '0;   // [1:0] operation
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [15:0] first_tile
   logic [RSP_USER_W-1:0] rsp_tuser;         // [0] blank, [1] newly_loaded, [2] full_res

   // Predictor state: slot + 1 per icon, icon + 1 per slot, zero meaning empty.
   logic [SLOT_NUM_W-1:0] icon_slot_map [ICON_COUNT_DEF];
   logic [ICON_NUM_W-1:0] slot_holder   [SLOT_COUNT_DEF];

   icon_request_type request_backlog [$];
   tile_answer_type  expected_tiles  [$];

   int   beats_taken = 0;
   int   fault_count = 0;
   int   cycle_count = 0;
   int   hold_left   = 0;
   logic hold_done   = 1'b0;
   logic req_fire    = 1'b0;
   int   working_set [SET_SIZE];

   wire quiet_stretch = (beats_taken >= QUIET_FROM) && (beats_taken < QUIET_TO);

   icon_slot_allocator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void wipe_tables();
      foreach (icon_slot_map[i]) icon_slot_map[i] = '0;
      foreach (slot_holder[i]) slot_holder[i] = '0;
   endfunction

   // Work out the result beat of one request and advance the local tables.
   function automatic tile_answer_type predict_answer(input icon_request_type rq);
      tile_answer_type ans;
      int              icon_num;
      int              slot_num;
      ans      = '0;
      icon_num = int'(rq.icon[ICON_NUM_W-1:0]);
      slot_num = 0;
      case (rq.op)
         OP_DRAW: begin
            if (rq.icon[ICON_W-1]) begin
               ans.blank = 1'b1;
            end else if (icon_num >= ICON_COUNT_DEF) begin
               // beyond the table: answer as if the pool were full
               ans.full_res = 1'b1;
            end else if (icon_slot_map[icon_num] != '0) begin
               slot_num = int'(icon_slot_map[icon_num]);
            end else begin
               // take the lowest free slot: scan downwards so the lowest wins
               for (int s = SLOT_COUNT_DEF - 1; s >= 0; s--)
                  if (slot_holder[s] == '0) slot_num = s + 1;
               if (slot_num == 0) begin
                  ans.full_res = 1'b1;
               end else begin
                  slot_holder[slot_num - 1] = ICON_NUM_W'(icon_num + 1);
                  icon_slot_map[icon_num]   = SLOT_NUM_W'(slot_num);
                  ans.newly_loaded          = 1'b1;
               end
            end
            if (!ans.blank) ans.first_tile = TILE_TOP - TILE_W'(slot_num * 4) + rq.pal;
         end
         OP_CLEAR: begin
            if (!rq.icon[ICON_W-1] && icon_num < ICON_COUNT_DEF
                && icon_slot_map[icon_num] != '0) begin
               slot_holder[int'(icon_slot_map[icon_num]) - 1] = '0;
               icon_slot_map[icon_num] = '0;
            end
         end
         OP_RESET_ALL: wipe_tables();
         default: ;
      endcase
      return ans;
   endfunction

   task automatic queue_request(input logic [OP_W-1:0] op, input int icon,
                                input logic [PAL_W-1:0] pal);
      icon_request_type rq;
      rq.op   = op;
      rq.icon = ICON_W'(icon);
      rq.pal  = pal;
      request_backlog.push_back(rq);
   endtask

   // Pick a fresh run of distinct icons; a stride of 7 never repeats within the table.
   task automatic pick_working_set();
      int base;
      base = $urandom_range(0, ICON_COUNT_DEF - 1);
      foreach (working_set[i]) working_set[i] = (base + i * 7) % ICON_COUNT_DEF;
   endtask

   // Request side: offer the next beat at the falling edge once the last one is taken.
   always @(negedge clock) begin : drive_requests
      icon_request_type rq;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (request_backlog.size() != 0
             && (quiet_stretch || $urandom_range(0, 99) >= IDLE_PCT)) begin
            rq = request_backlog.pop_front();
            req_tuser  <= rq.op;
            req_tdata  <= {5'b0, rq.pal, rq.icon};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result side: drop tready at random, and hold it low through the long hold-off.
   always @(negedge clock) begin
      if (reset || hold_left != 0) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet_stretch || $urandom_range(0, 99) >= IDLE_PCT;
      end
   end

   // Count the hold-off down in its own process; start it once, part way through.
   always @(posedge clock) begin
      if (!reset && !hold_done && beats_taken >= HOLD_OFF_AT) begin
         hold_left <= HOLD_OFF_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Predict on every accepted request beat; check every accepted result beat.
   always @(posedge clock) begin : watch_beats
      tile_answer_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            expected_tiles.push_back(predict_answer({req_tuser, req_tdata[10:0],
                                                     req_tdata[26:11]}));
            beats_taken <= beats_taken + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tiles.size() == 0) begin
               $error("result beat with none expected: tdata %h tuser %b",
                      rsp_tdata, rsp_tuser);
               fault_count = fault_count + 1;
            end else begin
               want = expected_tiles.pop_front();
               if (rsp_tdata != want.first_tile) begin
                  $error("first_tile: expected %h, got %h", want.first_tile, rsp_tdata);
                  fault_count = fault_count + 1;
               end
               if (rsp_tuser[0] != want.blank) begin
                  $error("blank: expected %b, got %b", want.blank, rsp_tuser[0]);
                  fault_count = fault_count + 1;
               end
               if (rsp_tuser[1] != want.newly_loaded) begin
                  $error("newly_loaded: expected %b, got %b", want.newly_loaded, rsp_tuser[1]);
                  fault_count = fault_count + 1;
               end
               if (rsp_tuser[2] != want.full_res) begin
                  $error("full_res: expected %b, got %b", want.full_res, rsp_tuser[2]);
                  fault_count = fault_count + 1;
               end
            end
         end
      end
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int pick;
      int icon;
      wipe_tables();

      // Directed: extremes of id and palette, blanks, out-of-table ids, no-op clears,
      // reuse of a freed slot, the spare code and a reset-all with stale entries.
      queue_request(OP_DRAW, 0, 16'h0000);
      queue_request(OP_DRAW, 0, 16'h1234);
      queue_request(OP_DRAW, 767, 16'hFFFF);
      queue_request(OP_DRAW, -1, 16'hABCD);
      queue_request(OP_DRAW, -1024, 16'hFFFF);
      queue_request(OP_DRAW, 768, 16'hFFFF);
      queue_request(OP_DRAW, 1023, 16'h0000);
      queue_request(OP_CLEAR, 5, 16'h0000);
      queue_request(OP_CLEAR, -1, 16'hFFFF);
      queue_request(OP_CLEAR, -1024, 16'h0000);
      queue_request(OP_CLEAR, 768, 16'h0000);
      queue_request(OP_CLEAR, 1023, 16'hFFFF);
      queue_request(OP_CLEAR, 0, 16'h0000);
      queue_request(OP_DRAW, 42, 16'h00FF);
      queue_request(OP_SPARE, 767, 16'hFFFF);
      queue_request(OP_SPARE, -1024, 16'h0000);
      queue_request(OP_DRAW, 767, 16'h0D00);
      queue_request(OP_RESET_ALL, 767, 16'hFFFF);
      queue_request(OP_DRAW, 767, 16'h0000);
      queue_request(OP_DRAW, 0, 16'h8000);
      queue_request(OP_CLEAR, 767, 16'h0000);
      queue_request(OP_DRAW, 767, 16'h7FFF);
      queue_request(OP_RESET_ALL, 0, 16'h0000);

      // Fill the pool from a working set larger than it, so the last draws find it full.
      pick_working_set();
      for (int i = 0; i < FILL_DRAWS; i++)
         queue_request(OP_DRAW, working_set[i], PAL_W'($urandom));

      // Mostly draws and clears on the working set, with noise mixed in.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         icon = working_set[$urandom_range(0, SET_SIZE - 1)];
         if (pick < 60) begin
            queue_request(OP_DRAW, icon, PAL_W'($urandom));
         end else if (pick < 75) begin
            queue_request(OP_CLEAR, icon, PAL_W'($urandom));
         end else if (pick < 80) begin
            queue_request(OP_DRAW, $urandom_range(0, ICON_COUNT_DEF - 1), PAL_W'($urandom));
         end else if (pick < 85) begin
            queue_request(OP_DRAW, -1 - int'($urandom_range(0, 1023)), PAL_W'($urandom));
         end else if (pick < 89) begin
            queue_request($urandom_range(0, 1) ? OP_DRAW : OP_CLEAR,
                          ICON_COUNT_DEF + $urandom_range(0, 255), PAL_W'($urandom));
         end else if (pick < 92) begin
            queue_request(OP_SPARE, int'($urandom_range(0, 2047)) - 1024, PAL_W'($urandom));
         end else if (pick < 94) begin
            queue_request(OP_RESET_ALL, int'($urandom_range(0, 2047)) - 1024,
                          PAL_W'($urandom));
            pick_working_set();
         end else if (pick < 97) begin
            queue_request(OP_CLEAR, $urandom_range(0, ICON_COUNT_DEF - 1), PAL_W'($urandom));
         end else begin
            queue_request(OP_CLEAR, -1 - int'($urandom_range(0, 1023)), PAL_W'($urandom));
         end
      end

      // Hold reset, then release it at a falling edge.
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every request to go in, then for every result to come back.
      while (request_backlog.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_tiles.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+sv
sv/isa_pkg.sv
sv/isa_ram.sv
sv/isa_slot_pool.sv
sv/icon_slot_allocator.sv
sim/testbench.sv
